// File: hdl/spa_pkg.sv
// Shared types and constants for the sparse polynomial accumulator.
// Used by the term cell, the core and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int EXP_W  = 16;
  localparam int COEF_W = 32;
  localparam int POS_W  = 4;
  localparam int HELD_W = 5;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_MERGED    = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_FULL      = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_READ_OOR  = 3'd5,
    ST_CLEARED   = 3'd6,
    ST_ZERO      = 3'd7
  } status_t;

  // Operation broadcast along the cell chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_MERGE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [EXP_W-1:0]   exp;
    logic signed [COEF_W-1:0]  coef;
  } cell_cmd_t;

endpackage

// File: hdl/spa_cell.sv
// One cell of the sorted term chain: holds one exponent and coefficient.
// Depends on spa_pkg for the chain command struct and field widths.
`timescale 1ns / 1ps

module spa_cell import spa_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic                          cmp_en,
  input  logic signed [EXP_W-1:0]       cmp_exp,
  input  cell_cmd_t                     cmd,
  input  logic                          left_gt,
  input  logic signed [EXP_W-1:0]       left_exp,
  input  logic signed [COEF_W-1:0]      left_coef,
  input  logic signed [EXP_W-1:0]       right_exp,
  input  logic signed [COEF_W-1:0]      right_coef,
  output logic                          gt,
  output logic                          eq,
  output logic signed [EXP_W-1:0]       exp_q,
  output logic signed [COEF_W-1:0]      coef_q
);

  localparam int CW = $clog2(DEPTH+1);

  logic                      live;
  logic                      gt_r, gt_nxt;
  logic                      eq_r, eq_nxt;
  logic signed [EXP_W-1:0]   exp_r, exp_nxt;
  logic signed [COEF_W-1:0]  coef_r, coef_nxt;

  // The cell holds a term only below the fill count.
  assign live = (count > CW'(IDX));

  // Compare flags are captured when an item is accepted.
  always_comb begin
    gt_nxt = gt_r;
    eq_nxt = eq_r;
    if (cmp_en) begin
      gt_nxt = live && (exp_r > cmp_exp);
      eq_nxt = live && (exp_r == cmp_exp);
    end
  end

  // Cells at or after the insert point shift right; on removal they shift left.
  always_comb begin
    exp_nxt  = exp_r;
    coef_nxt = coef_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (!gt_r) begin
          if (left_gt) begin
            exp_nxt  = cmd.exp;
            coef_nxt = cmd.coef;
          end else begin
            exp_nxt  = left_exp;
            coef_nxt = left_coef;
          end
        end
      end
      CELL_REMOVE: begin
        if (!gt_r) begin
          exp_nxt  = right_exp;
          coef_nxt = right_coef;
        end
      end
      CELL_MERGE: begin
        if (eq_r) begin
          coef_nxt = cmd.coef;
        end
      end
      default: begin
        exp_nxt  = exp_r;
        coef_nxt = coef_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      gt_r <= gt_nxt;
      eq_r <= eq_nxt;
    end
  end

  // Term storage has no reset; entries beyond the fill count are never read.
  always_ff @(posedge clk) begin
    exp_r  <= exp_nxt;
    coef_r <= coef_nxt;
  end

  assign gt     = gt_r;
  assign eq     = eq_r;
  assign exp_q  = exp_r;
  assign coef_q = coef_r;

endmodule

// File: hdl/sparse_polynomial_accumulator_core.sv
// A result is registered after its item passes the compare, gather and apply steps.
// No new item is taken until then; apply waits while the result register is not taken.
// The compare and gather passes run over the cell chain; the merge sum uses a single saturating adder.
// Reset: synchronous active-low; clears the term count, flags and the handshake state.
// Term storage is not cleared; entries past the count are never returned.
// Top level of the sparse polynomial accumulator; uses spa_pkg and spa_cell.
`timescale 1ns / 1ps

module sparse_polynomial_accumulator_core import spa_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic signed [EXP_W-1:0]   in_term_exponent,
  input  logic signed [COEF_W-1:0]  in_term_coefficient,
  input  logic [POS_W-1:0]          in_read_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic [HELD_W-1:0]         out_terms_held,
  output logic signed [EXP_W-1:0]   out_read_exponent,
  output logic signed [COEF_W-1:0]  out_read_coefficient
);

  localparam int CW   = $clog2(DEPTH+1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int READ_CELLS = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [HELD_W-1:0]         out_held_r, out_held_nxt;
  logic signed [EXP_W-1:0]   out_rexp_r, out_rexp_nxt;
  logic signed [COEF_W-1:0]  out_rcoef_r, out_rcoef_nxt;

  // Item held through the compare, gather and apply steps.
  cmd_t                      cmd_r, cmd_nxt;
  logic signed [EXP_W-1:0]   exp_r, exp_nxt;
  logic signed [COEF_W-1:0]  coef_r, coef_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      zero_r, zero_nxt;

  // Values gathered from the chain.
  logic signed [COEF_W-1:0]  match_coef_r, match_coef_nxt;
  logic                      any_eq_r, any_eq_nxt;
  logic                      rd_ok_r, rd_ok_nxt;
  logic signed [EXP_W-1:0]   rd_exp_r, rd_exp_nxt;
  logic signed [COEF_W-1:0]  rd_coef_r, rd_coef_nxt;

  logic                      accept;
  logic                      apply_fire;
  logic signed [COEF_W-1:0]  coef_in;
  logic signed [COEF_W:0]    sum;
  logic signed [COEF_W-1:0]  sum_sat;
  logic [CW+HELD_W-1:0]      count_ext;
  status_t                   status;
  cell_cmd_t                 cell_cmd;

  logic [DEPTH-1:0]          gt_vec;
  logic [DEPTH-1:0]          eq_vec;
  logic signed [EXP_W-1:0]   exp_arr  [DEPTH];
  logic signed [COEF_W-1:0]  coef_arr [DEPTH];

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // Subtract negates the coefficient, saturating the negated minimum.
  always_comb begin
    if (cmd_t'(in_command) == CMD_SUB) begin
      coef_in = (in_term_coefficient == COEF_MIN) ? COEF_MAX : -in_term_coefficient;
    end else begin
      coef_in = in_term_coefficient;
    end
  end

  // Cell chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                      l_gt;
    logic signed [EXP_W-1:0]   l_exp;
    logic signed [COEF_W-1:0]  l_coef;
    logic signed [EXP_W-1:0]   r_exp;
    logic signed [COEF_W-1:0]  r_coef;

    if (g == 0) begin : g_first
      assign l_gt   = 1'b1;
      assign l_exp  = exp_arr[g];
      assign l_coef = coef_arr[g];
    end else begin : g_mid
      assign l_gt   = gt_vec[g-1];
      assign l_exp  = exp_arr[g-1];
      assign l_coef = coef_arr[g-1];
    end

    if (g == DEPTH-1) begin : g_last
      assign r_exp  = exp_arr[g];
      assign r_coef = coef_arr[g];
    end else begin : g_inner
      assign r_exp  = exp_arr[g+1];
      assign r_coef = coef_arr[g+1];
    end

    spa_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .count      (count_r),
      .cmp_en     (accept),
      .cmp_exp    (in_term_exponent),
      .cmd        (cell_cmd),
      .left_gt    (l_gt),
      .left_exp   (l_exp),
      .left_coef  (l_coef),
      .right_exp  (r_exp),
      .right_coef (r_coef),
      .gt         (gt_vec[g]),
      .eq         (eq_vec[g]),
      .exp_q      (exp_arr[g]),
      .coef_q     (coef_arr[g])
    );
  end

  // Gather the matching coefficient and the term at the read position.
  always_comb begin
    match_coef_nxt = '0;
    any_eq_nxt     = 1'b0;
    rd_exp_nxt     = '0;
    rd_coef_nxt    = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (eq_vec[k]) begin
        match_coef_nxt = match_coef_nxt | coef_arr[k];
      end
      any_eq_nxt = any_eq_nxt | eq_vec[k];
      if (k < READ_CELLS && pos_r == POS_W'(k)) begin
        rd_exp_nxt  = exp_arr[k];
        rd_coef_nxt = coef_arr[k];
      end
    end
    rd_ok_nxt = (CMPW'(pos_r) < CMPW'(count_r));
  end

  // Saturating merge sum.
  always_comb begin
    sum = {match_coef_r[COEF_W-1], match_coef_r} + {coef_r[COEF_W-1], coef_r};
    if (sum > $signed({1'b0, COEF_MAX})) begin
      sum_sat = COEF_MAX;
    end else if (sum < $signed({1'b1, COEF_MIN})) begin
      sum_sat = COEF_MIN;
    end else begin
      sum_sat = sum[COEF_W-1:0];
    end
  end

  // Item outcome and the chain operation it issues.
  always_comb begin
    status        = ST_ZERO;
    count_nxt     = count_r;
    cell_cmd.op   = CELL_HOLD;
    cell_cmd.exp  = exp_r;
    cell_cmd.coef = coef_r;
    out_rexp_nxt  = '0;
    out_rcoef_nxt = '0;
    case (cmd_r)
      CMD_ADD, CMD_SUB: begin
        if (zero_r) begin
          status = ST_ZERO;
        end else if (any_eq_r) begin
          if (sum_sat == '0) begin
            status      = ST_CANCELLED;
            count_nxt   = count_r - 1'b1;
            cell_cmd.op = CELL_REMOVE;
          end else begin
            status        = ST_MERGED;
            cell_cmd.op   = CELL_MERGE;
            cell_cmd.coef = sum_sat;
          end
        end else if (count_r == CW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          status      = ST_INSERTED;
          count_nxt   = count_r + 1'b1;
          cell_cmd.op = CELL_INSERT;
        end
      end
      CMD_READ: begin
        if (rd_ok_r) begin
          status        = ST_READ_OK;
          out_rexp_nxt  = rd_exp_r;
          out_rcoef_nxt = rd_coef_r;
        end else begin
          status = ST_READ_OOR;
        end
      end
      CMD_CLEAR: begin
        status    = ST_CLEARED;
        count_nxt = '0;
      end
      default: begin
        status = ST_ZERO;
      end
    endcase
    if (!apply_fire) begin
      cell_cmd.op = CELL_HOLD;
      count_nxt   = count_r;
    end
    count_ext    = {{HELD_W{1'b0}}, count_nxt};
    out_held_nxt = count_ext[HELD_W-1:0];
  end

  // Sequencing and result register.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    cmd_nxt        = cmd_r;
    exp_nxt        = exp_r;
    coef_nxt       = coef_r;
    pos_nxt        = pos_r;
    zero_nxt       = zero_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = cmd_t'(in_command);
          exp_nxt   = in_term_exponent;
          coef_nxt  = coef_in;
          pos_nxt   = in_read_position;
          zero_nxt  = (in_term_coefficient == '0);
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_ZERO;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    exp_r  <= exp_nxt;
    coef_r <= coef_nxt;
    pos_r  <= pos_nxt;
    zero_r <= zero_nxt;
    if (state_r == S_MATCH) begin
      match_coef_r <= match_coef_nxt;
      any_eq_r     <= any_eq_nxt;
      rd_ok_r      <= rd_ok_nxt;
      rd_exp_r     <= rd_exp_nxt;
      rd_coef_r    <= rd_coef_nxt;
    end
    if (apply_fire) begin
      out_held_r  <= out_held_nxt;
      out_rexp_r  <= out_rexp_nxt;
      out_rcoef_r <= out_rcoef_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_terms_held       = out_held_r;
  assign out_read_exponent    = out_rexp_r;
  assign out_read_coefficient = out_rcoef_r;

`ifndef ASSERT_OFF
  // The fill count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("term count exceeds depth");

  // Stored exponents are distinct, so at most one cell matches.
  a_eq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("more than one cell matches the exponent");

  // Cells holding a larger exponent form a prefix of the chain.
  a_gt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((gt_vec + DEPTH'(1)) & gt_vec) == '0)
    else $error("greater-than flags are not a prefix");

  // An insertion grows the table by exactly one term.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_fire && status == ST_INSERTED) |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("insert did not advance the term count");

  // A result appears only after the apply step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_APPLY)
    else $error("result raised outside the apply step");
`endif

endmodule

// File: sim/tb_sparse_polynomial_accumulator_core.sv
// Testbench for the sparse polynomial accumulator core: directed table, then random phases.
// Checks results against typed rows or a model of the sorted table; depends on spa_pkg.
`timescale 1ns / 1ps

module tb_sparse_polynomial_accumulator_core;
  import spa_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLDOFF_LEN = 300;
  localparam int SETTLE_CYCLES = 16;

  // One expected result, laid out like the result ports.
  typedef struct packed {
    status_t                  status;
    logic [HELD_W-1:0]        held;
    logic signed [EXP_W-1:0]  rexp;
    logic signed [COEF_W-1:0] rcoef;
  } term_result_t;

  // One directed row; the expected fields count only where typed_in is set.
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [EXP_W-1:0]  e;
    logic signed [COEF_W-1:0] c;
    logic [POS_W-1:0]         pos;
    logic                     typed_in;
    status_t                  st;
    logic [HELD_W-1:0]        held;
    logic signed [EXP_W-1:0]  rexp;
    logic signed [COEF_W-1:0] rcoef;
  } directed_row_t;

  localparam int DIR_N = 24;

  directed_row_t directed_rows [DIR_N] = '{
    '{CMD_READ,  16'sd0,     32'sd0,          4'd0,  1'b1, ST_READ_OOR,  5'd0, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'sd0,     32'sd0,          4'd0,  1'b1, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_SUB,   -16'sd1,    32'sd0,          4'd0,  1'b1, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'sh7FFF,  COEF_MAX,        4'd0,  1'b1, ST_INSERTED,  5'd1, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'sh8000,  COEF_MIN,        4'd0,  1'b1, ST_INSERTED,  5'd2, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'sh7FFF,  32'sd1,          4'd0,  1'b1, ST_MERGED,    5'd2, 16'sd0, 32'sd0},
    '{CMD_READ,  16'sd0,     32'sd0,          4'd0,  1'b1, ST_READ_OK,   5'd2, 16'sh7FFF,
      COEF_MAX},
    '{CMD_SUB,   16'sh8000,  COEF_MIN,        4'd0,  1'b1, ST_MERGED,    5'd2, 16'sd0, 32'sd0},
    '{CMD_READ,  16'sd0,     32'sd0,          4'd1,  1'b1, ST_READ_OK,   5'd2, 16'sh8000,
      -32'sd1},
    '{CMD_ADD,   16'sh8000,  32'sd1,          4'd0,  1'b1, ST_CANCELLED, 5'd1, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'sd0,     -32'sd5,         4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'sh5555,  32'sh5555_5555,  4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'shAAAA,  32'shAAAA_AAAA,  4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_READ,  16'sd0,     32'sd0,          4'd1,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_READ,  16'sd0,     32'sd0,          4'd15, 1'b1, ST_READ_OOR,  5'd4, 16'sd0, 32'sd0},
    '{CMD_SUB,   16'sd0,     -32'sd5,         4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_ADD,   16'shAAAA,  COEF_MIN,        4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_READ,  16'sd0,     32'sd0,          4'd2,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_SUB,   16'sh7FFF,  32'sd1,          4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_CLEAR, 16'sd0,     32'sd0,          4'd0,  1'b1, ST_CLEARED,   5'd0, 16'sd0, 32'sd0},
    '{CMD_READ,  16'sd0,     32'sd0,          4'd0,  1'b1, ST_READ_OOR,  5'd0, 16'sd0, 32'sd0},
    '{CMD_SUB,   16'sd7,     COEF_MAX,        4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_READ,  16'sd0,     32'sd0,          4'd0,  1'b0, ST_ZERO,      5'd0, 16'sd0, 32'sd0},
    '{CMD_CLEAR, 16'sh7FFF,  32'shFFFF_FFFF,  4'd15, 1'b1, ST_CLEARED,   5'd0, 16'sd0, 32'sd0}
  };

  // Clock, reset and block ports.
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_command = CMD_ADD;
  logic signed [EXP_W-1:0]  in_term_exponent = '0;
  logic signed [COEF_W-1:0] in_term_coefficient = '0;
  logic [POS_W-1:0]         in_read_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               out_status;
  logic [HELD_W-1:0]        out_terms_held;
  logic signed [EXP_W-1:0]  out_read_exponent;
  logic signed [COEF_W-1:0] out_read_coefficient;

  // Outputs captured at the falling edge, so the rising edge sees settled values.
  logic                     in_ready_s = 1'b0;
  logic                     out_valid_s = 1'b0;
  logic [2:0]               out_status_s;
  logic [HELD_W-1:0]        out_held_s;
  logic signed [EXP_W-1:0]  out_rexp_s;
  logic signed [COEF_W-1:0] out_rcoef_s;

  // Local copy of the term table.
  logic signed [EXP_W-1:0]  poly_exp  [DEPTH];
  logic signed [COEF_W-1:0] poly_coef [DEPTH];
  int                       poly_count = 0;

  term_result_t             pending_results [$];
  int                       mismatch_count = 0;
  int                       results_checked = 0;
  int                       items_sent = 0;
  int                       status_seen [8];
  int                       burst_left = 0;
  int                       holdoff_asks = 0;
  int                       holdoff_done = 0;
  int                       cycle_count = 0;

  sparse_polynomial_accumulator_core #(.DEPTH(DEPTH)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_term_exponent     (in_term_exponent),
    .in_term_coefficient  (in_term_coefficient),
    .in_read_position     (in_read_position),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_terms_held       (out_terms_held),
    .out_read_exponent    (out_read_exponent),
    .out_read_coefficient (out_read_coefficient)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(negedge clk) begin
    in_ready_s   <= in_ready;
    out_valid_s  <= out_valid;
    out_status_s <= out_status;
    out_held_s   <= out_terms_held;
    out_rexp_s   <= out_read_exponent;
    out_rcoef_s  <= out_read_coefficient;
  end

  // Clamp a wide sum to the signed 32-bit range.
  function automatic longint saturate(longint v);
    if (v > longint'(COEF_MAX)) return longint'(COEF_MAX);
    if (v < longint'(COEF_MIN)) return longint'(COEF_MIN);
    return v;
  endfunction

  // Insert, merge or cancel one term in the sorted table.
  function automatic status_t fold_term(logic signed [EXP_W-1:0] e, longint term_c);
    int     slot;
    int     k;
    longint sum;
    slot = 0;
    while (slot < poly_count && poly_exp[slot] > e) slot++;
    if (slot < poly_count && poly_exp[slot] == e) begin
      sum = saturate(longint'(poly_coef[slot]) + term_c);
      if (sum == 0) begin
        for (k = slot; k + 1 < poly_count; k++) begin
          poly_exp[k]  = poly_exp[k+1];
          poly_coef[k] = poly_coef[k+1];
        end
        poly_count--;
        return ST_CANCELLED;
      end
      poly_coef[slot] = sum[COEF_W-1:0];
      return ST_MERGED;
    end
    if (poly_count >= DEPTH) return ST_FULL;
    for (k = poly_count; k > slot; k--) begin
      poly_exp[k]  = poly_exp[k-1];
      poly_coef[k] = poly_coef[k-1];
    end
    poly_exp[slot]  = e;
    poly_coef[slot] = term_c[COEF_W-1:0];
    poly_count++;
    return ST_INSERTED;
  endfunction

  // Work out the result of one item and update the local table.
  function automatic term_result_t predict_item(cmd_t cmd, logic signed [EXP_W-1:0] e,
                                                logic signed [COEF_W-1:0] c,
                                                logic [POS_W-1:0] pos);
    term_result_t r;
    longint       term_c;
    r = '0;
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        if (c == 0) begin
          r.status = ST_ZERO;
        end else begin
          term_c = (cmd == CMD_SUB) ? saturate(-longint'(c)) : longint'(c);
          r.status = fold_term(e, term_c);
        end
      end
      CMD_READ: begin
        if (int'(pos) < poly_count) begin
          r.status = ST_READ_OK;
          r.rexp   = poly_exp[pos];
          r.rcoef  = poly_coef[pos];
        end else begin
          r.status = ST_READ_OOR;
        end
      end
      default: begin
        poly_count = 0;
        r.status   = ST_CLEARED;
      end
    endcase
    r.held = poly_count[HELD_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on result %0d, %s: got %0d, expected %0d",
             $time, results_checked, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item, in bursts with random gaps; returns at the edge that accepts it.
  task automatic send_item(cmd_t cmd, logic signed [EXP_W-1:0] e,
                           logic signed [COEF_W-1:0] c, logic [POS_W-1:0] pos,
                           logic typed_in, term_result_t typed_want);
    term_result_t predicted;
    int           gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    predicted = predict_item(cmd, e, c, pos);
    pending_results.push_back(typed_in ? typed_want : predicted);
    status_seen[predicted.status]++;
    items_sent++;
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_term_exponent    <= e;
    in_term_coefficient <= c;
    in_read_position    <= pos;
    @(posedge clk);
    while (!in_ready_s) @(posedge clk);
  endtask

  task automatic send_term(cmd_t cmd, logic signed [EXP_W-1:0] e,
                           logic signed [COEF_W-1:0] c, logic [POS_W-1:0] pos);
    send_item(cmd, e, c, pos, 1'b0, '0);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      3, 4, 5: return COEF_W'($urandom_range(0, 8)) - 32'sd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [EXP_W-1:0] pick_exp();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return EXP_W'($urandom_range(0, 20)) - 16'sd10;
      default: return EXP_W'($urandom);
    endcase
  endfunction

  function automatic cmd_t pick_addsub();
    return $urandom_range(0, 1) ? CMD_SUB : CMD_ADD;
  endfunction

  // Remove a held term by subtracting its coefficient or adding its negation (not exact for COEF_MIN).
  task automatic cancel_held_term();
    int slot;
    slot = $urandom_range(0, poly_count - 1);
    if ($urandom_range(0, 1))
      send_term(CMD_SUB, poly_exp[slot], poly_coef[slot], POS_W'($urandom));
    else
      send_term(CMD_ADD, poly_exp[slot], -poly_coef[slot], POS_W'($urandom));
  endtask

  // Clear, try to fill the table to the brim, then push new terms, merges, cancels and reads at it.
  task automatic fill_phase();
    int tries;
    int k;
    send_term(CMD_CLEAR, EXP_W'($urandom), $urandom, POS_W'($urandom));
    tries = 0;
    while (poly_count < DEPTH && tries < 40) begin
      send_term(pick_addsub(), EXP_W'($urandom), pick_coef(), POS_W'($urandom));
      tries++;
    end
    for (k = 0; k < 12; k++) begin
      case ($urandom_range(0, 4))
        0:       send_term(pick_addsub(), pick_exp(), pick_coef(), POS_W'($urandom));
        1:       send_term(CMD_READ, EXP_W'($urandom), $urandom, POS_W'($urandom));
        2: begin
          if (poly_count > 0)
            send_term(pick_addsub(), poly_exp[$urandom_range(0, poly_count - 1)],
                      pick_coef(), POS_W'($urandom));
          else
            send_term(CMD_READ, EXP_W'($urandom), $urandom, POS_W'($urandom));
        end
        3: begin
          if (poly_count > 0) cancel_held_term();
          else send_term(CMD_ADD, EXP_W'($urandom), pick_coef(), POS_W'($urandom));
        end
        default: send_term(pick_addsub(), EXP_W'($urandom), pick_coef(),
                           POS_W'($urandom));
      endcase
    end
  endtask

  // Work a small set of exponents hard, so merges, cancels and saturation recur.
  task automatic accumulate_phase();
    logic signed [EXP_W-1:0] pool [6];
    int                      k;
    foreach (pool[p]) pool[p] = pick_exp();
    for (k = 0; k < 30; k++) begin
      case ($urandom_range(0, 9))
        0, 1: send_term(CMD_READ, EXP_W'($urandom), $urandom,
                        POS_W'($urandom_range(0, 7)));
        2: begin
          if (poly_count > 0) cancel_held_term();
          else send_term(CMD_ADD, pool[$urandom_range(0, 5)], pick_coef(),
                         POS_W'($urandom));
        end
        default: send_term(pick_addsub(), pool[$urandom_range(0, 5)], pick_coef(),
                           POS_W'($urandom));
      endcase
    end
  endtask

  // Fully random items, clear included.
  task automatic noise_phase();
    int k;
    for (k = 0; k < 20; k++) begin
      send_term(cmd_t'($urandom_range(0, 3)), EXP_W'($urandom), $urandom,
                POS_W'($urandom));
    end
  endtask

  // Result side: stall on a pattern of its own, with a long hold-off on request.
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_done != holdoff_asks) begin
        hold_left = HOLDOFF_LEN;
        holdoff_done++;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(5, 80);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    term_result_t want;
    if (rst_n && out_valid_s && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", longint'(out_status_s),
                        longint'(0));
      end else begin
        want = pending_results.pop_front();
        if (out_status_s != want.status)
          report_mismatch("status", longint'(out_status_s), longint'(want.status));
        if (out_held_s != want.held)
          report_mismatch("terms_held", longint'(out_held_s), longint'(want.held));
        if (out_rexp_s != want.rexp)
          report_mismatch("read_exponent", longint'(out_rexp_s), longint'(want.rexp));
        if (out_rcoef_s != want.rcoef)
          report_mismatch("read_coefficient", longint'(out_rcoef_s), longint'(want.rcoef));
      end
      results_checked++;
    end
  end

  // Guard against a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("FAIL");
    $finish;
  end

  // Main stimulus: reset, directed table, random phases, drain.
  initial begin
    int            i;
    term_result_t  typed_want;
    foreach (status_seen[s]) status_seen[s] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_N; i++) begin
      typed_want = '{directed_rows[i].st, directed_rows[i].held,
                     directed_rows[i].rexp, directed_rows[i].rcoef};
      send_item(directed_rows[i].cmd, directed_rows[i].e, directed_rows[i].c,
                directed_rows[i].pos, directed_rows[i].typed_in, typed_want);
    end
    wait_drained();

    while (items_sent < DIR_N + RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0, 1, 2:    fill_phase();
        3, 4, 5, 6: accumulate_phase();
        default:    noise_phase();
      endcase
      // The block fills up and stalls its input while the result side holds off.
      if (holdoff_asks == 0 && items_sent > 600) holdoff_asks++;
      else if (holdoff_asks == 1 && items_sent > 1400) holdoff_asks++;
      else if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", longint'(0),
                      longint'(pending_results.size()));

    $display("Covered %0d items (%0d from the directed table), %0d results checked.",
             items_sent, DIR_N, results_checked);
    $display("Inserted %0d, merged %0d, cancelled %0d, full %0d, read %0d/%0d, clear %0d, zero %0d.",
             status_seen[ST_INSERTED], status_seen[ST_MERGED], status_seen[ST_CANCELLED],
             status_seen[ST_FULL], status_seen[ST_READ_OK], status_seen[ST_READ_OOR],
             status_seen[ST_CLEARED], status_seen[ST_ZERO]);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/spa_pkg.sv
hdl/spa_cell.sv
hdl/sparse_polynomial_accumulator_core.sv
sim/tb_sparse_polynomial_accumulator_core.sv
